// ----- design/assert_macros.svh -----
// assertion macros used by the resampler rtl file
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");

`else

`define ASSERT_CLK(name, clk, rst_n, prop)

`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

// ----- design/slir_pkg.sv -----
// types and constants of the stereo linear interpolation resampler
// no dependencies
`default_nettype none

package slir_pkg;

  localparam int FifoDepthDefault = 128;
  localparam int OutQueueDepth    = 8;
  localparam logic [16:0] OneSample = 17'h10000;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic {
    REG_STEP = 1'b0
  } reg_idx_e;

endpackage

`default_nettype wire

// ----- design/stereo_linear_interp_resampler.sv -----
// tick beats pass stage 1, stage 2 and the output queue; throughput: one beat
// per cycle, push or tick, while in_ready_o is high; the sample memory has
// one write and one read port, and up to 8 ticks may wait for out_ready_i
// reset: asynchronous, clears pointers, counts, phase, samples and step to 1.0
// sample memory contents are not cleared; no entry is read before written
`default_nettype none

`include "assert_macros.svh"

module stereo_linear_interp_resampler #(
  parameter int FIFO_DEPTH = slir_pkg::FifoDepthDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire slir_pkg::op_e op_i,
  input  wire logic [15:0]  left_in_i,
  input  wire logic [15:0]  right_in_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [31:0]       out_word_o,
  output logic              underrun_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import slir_pkg::*;

  localparam int PtrW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW  = $clog2(FIFO_DEPTH + 1);
  localparam int OqPtrW = $clog2(OutQueueDepth);
  localparam int OqCntW = $clog2(OutQueueDepth + 1);

  // config
  logic [16:0] step_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= OneSample;
    end else if (cfg_wr) begin
      step_q <= pwdata[16:0];
    end
  end

  assign prdata = (paddr[2] == REG_STEP) ? {15'd0, step_q} : 32'd0;

  // handshake
  logic [OqCntW-1:0] pend_q, pend_d;
  logic in_fire, tick_fire, push_fire, out_fire;

  assign in_ready_o = (pend_q < OqCntW'(OutQueueDepth));
  assign in_fire    = in_valid_i && in_ready_o;
  assign tick_fire  = in_fire && (op_i == OP_TICK);
  assign push_fire  = in_fire && (op_i == OP_PUSH);

  // control state, updated at accept
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic [15:0]     phase_q, phase_d;
  logic [16:0]     step_sat;
  logic [16:0]     phase_sum;
  logic            fifo_full, fifo_empty, wrap, do_write, do_pop;

  assign fifo_full  = (fill_q == CntW'(FIFO_DEPTH));
  assign fifo_empty = (fill_q == '0);
  assign step_sat   = (step_q > OneSample) ? OneSample : step_q;
  assign phase_sum  = {1'b0, phase_q} + step_sat;
  assign wrap       = phase_sum[16];
  assign do_write   = push_fire && !fifo_full;
  assign do_pop     = tick_fire && !fifo_empty && wrap;

  always_comb begin
    fill_d  = fill_q;
    phase_d = phase_q;
    if (do_write) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop) begin
      fill_d = fill_q - 1'b1;
    end
    if (tick_fire && !fifo_empty) begin
      phase_d = phase_sum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      phase_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      phase_q <= phase_d;
      if (do_write) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  // sample memory
  logic [31:0] sample_mem [FIFO_DEPTH];
  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      sample_mem[wr_ptr_q] <= {left_in_i, right_in_i};
    end
    if (do_pop) begin
      rd_data_q <= sample_mem[rd_ptr_q];
    end
  end

  // stage 1: products and sample update
  logic        s1_valid_q, s1_wrap_q, s1_under_q;
  logic [15:0] s1_phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= tick_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      s1_wrap_q  <= do_pop;
      s1_under_q <= fifo_empty;
      s1_phase_q <= phase_q;
    end
  end

  logic signed [15:0] l_prev_q, l_next_q, r_prev_q, r_next_q;
  logic        [16:0] w_prev;
  logic signed [33:0] p_lp, p_ln, p_rp, p_rn;

  assign w_prev = OneSample - {1'b0, s1_phase_q};
  assign p_lp   = l_prev_q * $signed({1'b0, w_prev});
  assign p_ln   = l_next_q * $signed({2'b00, s1_phase_q});
  assign p_rp   = r_prev_q * $signed({1'b0, w_prev});
  assign p_rn   = r_next_q * $signed({2'b00, s1_phase_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_prev_q <= '0;
      l_next_q <= '0;
      r_prev_q <= '0;
      r_next_q <= '0;
    end else if (s1_valid_q && s1_wrap_q) begin
      l_prev_q <= l_next_q;
      r_prev_q <= r_next_q;
      l_next_q <= $signed(rd_data_q[31:16]);
      r_next_q <= $signed(rd_data_q[15:0]);
    end
  end

  // stage 2: sums
  logic               s2_valid_q, s2_under_q;
  logic signed [33:0] s2_lp_q, s2_ln_q, s2_rp_q, s2_rn_q;
  logic        [33:0] sum_l, sum_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_under_q <= s1_under_q;
      s2_lp_q    <= p_lp;
      s2_ln_q    <= p_ln;
      s2_rp_q    <= p_rp;
      s2_rn_q    <= p_rn;
    end
  end

  assign sum_l = s2_lp_q + s2_ln_q;
  assign sum_r = s2_rp_q + s2_rn_q;

  // output queue
  logic [31:0]       oq_word [OutQueueDepth];
  logic              oq_under [OutQueueDepth];
  logic [OqPtrW-1:0] oq_wr_q, oq_rd_q;
  logic [OqCntW-1:0] oq_cnt_q;

  assign out_valid_o = (oq_cnt_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign out_word_o  = oq_word[oq_rd_q];
  assign underrun_o  = oq_under[oq_rd_q];

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      oq_word[oq_wr_q]  <= {sum_l[31:16], sum_r[31:16]};
      oq_under[oq_wr_q] <= s2_under_q;
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (tick_fire && !out_fire) begin
      pend_d = pend_q + 1'b1;
    end else if (!tick_fire && out_fire) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
      pend_q   <= '0;
    end else begin
      pend_q <= pend_d;
      if (s2_valid_q) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (out_fire) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
      if (s2_valid_q && !out_fire) begin
        oq_cnt_q <= oq_cnt_q + 1'b1;
      end else if (!s2_valid_q && out_fire) begin
        oq_cnt_q <= oq_cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_queue_within_pending, clk_i, rst_ni, oq_cnt_q <= pend_q)
  `ASSERT_NEVER(a_fill_overflow, clk_i, rst_ni, fill_q > CntW'(FIFO_DEPTH))
  `ASSERT_CLK(a_empty_tick_underruns, clk_i, rst_ni,
              (tick_fire && fifo_empty) |=> (s1_valid_q && s1_under_q && !s1_wrap_q))
  `ASSERT_CLK(a_tick_reaches_queue, clk_i, rst_ni, tick_fire |=> ##1 s2_valid_q)

endmodule

`default_nettype wire
